// ===== hw/rtl/upme_pkg.sv =====
// Shared constants of the user page map engine.
`timescale 1ns / 1ps
package upme_pkg;
  localparam logic [63:0] DRAM_LO = 64'h0000_0000_4000_0000;
  localparam logic [63:0] DRAM_HI = 64'h0000_0000_8000_0000;
  localparam logic [63:0] ADDR_MASK = 64'h0000_FFFF_FFFF_F000;
  localparam logic [63:0] L3_ATTR = 64'h0020_0000_0000_0747;
  localparam logic [63:0] UXN_BIT = 64'h0040_0000_0000_0000;
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_DISABLED = 3'd1;
  localparam logic [2:0] ST_RANGE = 3'd2;
  localparam logic [2:0] ST_POOL_FULL = 3'd3;
  localparam logic [2:0] ST_LIST_FULL = 3'd4;
  localparam logic [0:0] REG_MMU_ENABLED = 1'b0;
  localparam logic [0:0] REG_POOL_BASE = 1'b1;
  localparam logic ACT_MAP = 1'b0;
  localparam int KEY_W = 18;
endpackage

// ===== hw/rtl/upme_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module upme_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/user_page_map_engine_top.sv =====
// Top level of the user page map engine.
//
// Usage: raise start with action, address, length and user_exec while busy is
// low; the item is taken at that edge and busy rises on the next cycle. When
// the item is done, done pulses for one cycle with all result fields valid.
// A map walks the pool slot owners one per cycle, then searches the page list
// entry by entry through the list RAM read port, a read state and a compare state
// for each entry. A check walks the pages of the range in order and searches the
// list for each, stopping at the first page that is missing or outside DRAM;
// empty, zero-length, wrapping or oversized ranges finish without a search.
// Only one item is in flight, and a new item may be taken at the edge that ends
// the done cycle.
// Configuration writes are taken at any time on cfg_valid; cfg_ready is high.
// Reset clears the slot owners, the page count and the registers; the list
// RAM itself is not cleared, since only entries below the count are read.
// The receiver cannot stall: each result appears exactly once with done.
`timescale 1ns / 1ps
module user_page_map_engine_top import upme_pkg::*; #(
  parameter int POOL_SLOTS = 32,
  parameter int LIST_DEPTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [63:0] address,
  input  logic [63:0] length,
  input  logic        user_exec,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic        buffer_ok,
  output logic        new_table,
  output logic [4:0]  table_slot,
  output logic [8:0]  l2_position,
  output logic [63:0] l2_descriptor,
  output logic [8:0]  l3_position,
  output logic [63:0] l3_descriptor
);
  localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int LW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PRE   = 8'b0000_0010,
    S_SLOT  = 8'b0000_0100,
    S_DESC  = 8'b0000_1000,
    S_RD    = 8'b0001_0000,
    S_CMP   = 8'b0010_0000,
    S_NEXT  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  logic mmu_enabled;
  logic [47:0] pool_base;
  logic [POOL_SLOTS-1:0] own_valid;
  logic [8:0] own_idx [POOL_SLOTS];
  logic [CW-1:0] page_count;

  logic act;
  logic exec;
  logic [63:0] first;
  logic [63:0] remain;
  logic [63:0] page;
  logic [SW-1:0] sidx;
  logic hit_found, free_found;
  logic [SW-1:0] hit_slot, spare_slot;
  logic [CW-1:0] lidx;
  logic found;
  logic [KEY_W-1:0] key;

  logic ram_we;
  logic [LW-1:0] ram_raddr;
  logic [KEY_W-1:0] ram_rdata;
  logic [64:0] end_sum;
  logic [63:0] last_pg;
  logic [63:0] npages;
  logic [63:0] tbl;

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);
  assign ram_raddr = lidx[LW-1:0];
  assign ram_we = (state == S_DESC) && !act && !found && (page_count < CW'(LIST_DEPTH));
  assign key = KEY_W'((page - DRAM_LO) >> 12);
  assign end_sum = {1'b0, first} + {1'b0, remain};
  assign last_pg = (end_sum[63:0] - 64'd1) >> 12;
  assign npages = last_pg - (first >> 12) + 64'd1;

  upme_ram #(.WIDTH(KEY_W), .DEPTH(LIST_DEPTH)) u_list (
    .clk(clk), .we(ram_we), .waddr(page_count[LW-1:0]), .wdata(key),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mmu_enabled <= 1'b0;
      pool_base <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MMU_ENABLED: mmu_enabled <= cfg_data[0];
        REG_POOL_BASE: pool_base <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      own_valid <= '0;
      page_count <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      case (state)
        S_IDLE: begin
          if (start) begin
            act <= action;
            exec <= user_exec;
            first <= address;
            remain <= length;
            page <= {address[63:12], 12'd0};
            status <= ST_OK;
            buffer_ok <= 1'b0;
            new_table <= 1'b0;
            table_slot <= '0;
            l2_position <= '0;
            l2_descriptor <= '0;
            l3_position <= '0;
            l3_descriptor <= '0;
            sidx <= '0;
            hit_found <= 1'b0;
            free_found <= 1'b0;
            lidx <= '0;
            found <= 1'b0;
            state <= S_PRE;
          end
        end
        S_PRE: begin
          if (act == ACT_MAP) begin
            if (!mmu_enabled) begin
              status <= ST_DISABLED;
              state <= S_DONE;
            end else if (page < DRAM_LO || page >= DRAM_HI) begin
              status <= ST_RANGE;
              state <= S_DONE;
            end else begin
              state <= S_SLOT;
            end
          end else begin
            if (page_count == '0 || remain == '0 || end_sum[64]
                || npages > 64'(page_count)) begin
              state <= S_DONE;
            end else begin
              page <= {first[63:12], 12'd0};
              remain <= npages;
              state <= S_NEXT;
            end
          end
        end
        S_SLOT: begin
          if (own_valid[sidx] && own_idx[sidx] == page[29:21] && !hit_found) begin
            hit_found <= 1'b1;
            hit_slot <= sidx;
          end
          if (!own_valid[sidx] && !free_found) begin
            free_found <= 1'b1;
            spare_slot <= sidx;
          end
          if (sidx == SW'(POOL_SLOTS - 1)) begin
            state <= S_RD;
          end else begin
            sidx <= sidx + SW'(1);
          end
        end
        S_RD: begin
          if (act == ACT_MAP && !hit_found && !free_found) begin
            status <= ST_POOL_FULL;
            state <= S_DONE;
          end else if (lidx >= page_count) begin
            state <= (act == ACT_MAP) ? S_DESC : S_DONE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (ram_rdata == key) begin
            found <= 1'b1;
            if (act == ACT_MAP) begin
              state <= S_DESC;
            end else begin
              page <= page + 64'h1000;
              remain <= remain - 64'd1;
              state <= S_NEXT;
            end
          end else begin
            lidx <= lidx + CW'(1);
            state <= S_RD;
          end
        end
        S_DESC: begin
          if (!hit_found) begin
            own_valid[spare_slot] <= 1'b1;
            own_idx[spare_slot] <= page[29:21];
            new_table <= 1'b1;
          end
          table_slot <= 5'(hit_found ? hit_slot : spare_slot);
          l2_position <= page[29:21];
          l3_position <= page[20:12];
          l2_descriptor <= 64'd3 | (tbl & ADDR_MASK);
          l3_descriptor <= L3_ATTR | (page & ADDR_MASK) | (exec ? 64'd0 : UXN_BIT);
          if (!found) begin
            if (page_count < CW'(LIST_DEPTH)) begin
              page_count <= page_count + CW'(1);
            end else begin
              status <= ST_LIST_FULL;
            end
          end
          state <= S_DONE;
        end
        S_NEXT: begin
          if (remain == '0) begin
            buffer_ok <= 1'b1;
            state <= S_DONE;
          end else if (page < DRAM_LO || page >= DRAM_HI) begin
            state <= S_DONE;
          end else begin
            lidx <= '0;
            found <= 1'b0;
            state <= S_RD;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign tbl = {16'd0, pool_base + {(48 - 12 - SW)'(0),
                                    (hit_found ? hit_slot : spare_slot), 12'd0}};
endmodule

// ===== bench/tb_user_page_map_engine_top.sv =====
// Self-checking bench for the user page map engine: directed table, random items and a full pool.
`timescale 1ns / 1ps
module tb_user_page_map_engine_top;
  import upme_pkg::*;

  localparam int SLOTS = 32;
  localparam int DEPTH = 2048;
  localparam longint LIMIT = 40_000_000;

  typedef struct packed {
    logic [2:0]  status;
    logic        buffer_ok;
    logic        new_table;
    logic [4:0]  table_slot;
    logic [8:0]  l2_position;
    logic [63:0] l2_descriptor;
    logic [8:0]  l3_position;
    logic [63:0] l3_descriptor;
  } page_result_t;

  typedef struct {
    logic         act;
    logic [63:0]  addr;
    logic [63:0]  len;
    logic         ex;
    bit           typed;
    page_result_t res;
  } dir_row_t;

  logic clk, rst, start, busy, action, user_exec, cfg_valid, cfg_ready, cfg_index, done;
  logic [63:0] address, length, cfg_data;
  logic [2:0] status;
  logic buffer_ok, new_table;
  logic [4:0] table_slot;
  logic [8:0] l2_position, l3_position;
  logic [63:0] l2_descriptor, l3_descriptor;

  user_page_map_engine_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .address(address), .length(length), .user_exec(user_exec),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .status(status), .buffer_ok(buffer_ok),
    .new_table(new_table), .table_slot(table_slot), .l2_position(l2_position),
    .l2_descriptor(l2_descriptor), .l3_position(l3_position),
    .l3_descriptor(l3_descriptor)
  );

  logic        mmu_on;
  logic [47:0] base_reg;
  logic        owner_ok [SLOTS];
  logic [8:0]  owner_l2 [SLOTS];
  logic [17:0] page_keys [$];
  bit          page_seen [int];
  page_result_t pending_results [$];
  int  errors = 0;
  bit  quiet = 0;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic range_recorded(input logic [63:0] va, input logic [63:0] len);
    logic [63:0] fin, first, last, n, pg;
    if (page_keys.size() == 0 || len == 0) return 1'b0;
    fin = va + len;
    if (fin < va) return 1'b0;
    first = va >> 12;
    last = (fin - 64'd1) >> 12;
    n = last - first + 64'd1;
    if (n > 64'(page_keys.size())) return 1'b0;
    for (longint k = 0; k < longint'(n); k++) begin
      pg = (first + 64'(k)) << 12;
      if (pg < DRAM_LO || pg >= DRAM_HI) return 1'b0;
      if (!page_seen.exists(int'((pg - DRAM_LO) >> 12))) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic page_result_t map_or_check(input logic act, input logic [63:0] a,
                                                input logic [63:0] l, input logic ex);
    page_result_t r;
    logic [63:0] pg;
    logic [8:0] l2i;
    int hit, spare, slot;
    int key;
    r = '0;
    hit = -1;
    spare = -1;
    if (act != ACT_MAP) begin
      r.buffer_ok = range_recorded(a, l);
      return r;
    end
    if (!mmu_on) begin
      r.status = ST_DISABLED;
      return r;
    end
    pg = a & ~64'hFFF;
    if (pg < DRAM_LO || pg >= DRAM_HI) begin
      r.status = ST_RANGE;
      return r;
    end
    l2i = pg[29:21];
    for (int i = 0; i < SLOTS; i++) begin
      if (owner_ok[i] && owner_l2[i] == l2i) begin
        hit = i;
        break;
      end
      if (spare < 0 && !owner_ok[i]) spare = i;
    end
    if (hit >= 0) begin
      slot = hit;
    end else if (spare >= 0) begin
      slot = spare;
      owner_ok[slot] = 1'b1;
      owner_l2[slot] = l2i;
      r.new_table = 1'b1;
    end else begin
      r.status = ST_POOL_FULL;
      return r;
    end
    r.table_slot = slot[4:0];
    r.l2_position = l2i;
    r.l3_position = pg[20:12];
    r.l2_descriptor = 64'd3 | (({16'd0, base_reg} + (64'(slot) << 12)) & ADDR_MASK);
    r.l3_descriptor = L3_ATTR | (pg & ADDR_MASK) | (ex ? 64'd0 : UXN_BIT);
    key = int'((pg - DRAM_LO) >> 12);
    if (!page_seen.exists(key)) begin
      if (page_keys.size() >= DEPTH) begin
        r.status = ST_LIST_FULL;
      end else begin
        page_keys.push_back(key[17:0]);
        page_seen[key] = 1;
      end
    end
    return r;
  endfunction

  task automatic issue(input logic act, input logic [63:0] a, input logic [63:0] l,
                       input logic ex, input bit typed, input page_result_t typed_res);
    page_result_t r;
    if (!quiet && $urandom_range(99) < 17) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    address <= a;
    length <= l;
    user_exec <= ex;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = map_or_check(act, a, l, ex);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MMU_ENABLED) mmu_on = value[0];
    else base_reg = value[47:0];
  endtask

  task automatic configure(input logic on, input logic [47:0] base);
    drain();
    write_reg(REG_MMU_ENABLED, {$urandom, $urandom} & ~64'd1 | 64'(on));
    write_reg(REG_POOL_BASE, {$urandom, $urandom} & ~64'hFFFF_FFFF_FFFF | 64'(base));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item();
    int pick;
    logic [63:0] a, l;
    logic [8:0] l2i;
    pick = $urandom_range(99);
    if (pick < 10) begin
      issue(1'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom},
            1'($urandom_range(1)), 1'b0, '0);
    end else if (pick < 60 || page_keys.size() == 0) begin
      l2i = ($urandom_range(3) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(5));
      a = DRAM_LO | (64'(l2i) << 21) | (64'($urandom_range(7)) << 12)
          | 64'($urandom_range(4095));
      if ($urandom_range(7) == 0) a[20:12] = 9'($urandom);
      issue(ACT_MAP, a, {$urandom, $urandom}, 1'($urandom_range(1)), 1'b0, '0);
    end else begin
      a = DRAM_LO + (64'(page_keys[$urandom_range(page_keys.size() - 1)]) << 12)
          + 64'($urandom_range(4095)) - 64'($urandom_range(1) * 4096);
      l = ($urandom_range(9) == 0) ? 64'd0 : 64'($urandom_range(1, 12288));
      issue(1'b1, a, l, 1'($urandom_range(1)), 1'b0, '0);
    end
  endtask

  dir_row_t dir_rows [18];
  page_result_t zero_res, dis_res, rng_res;

  initial begin
    zero_res = '0;
    dis_res = '0;
    dis_res.status = ST_DISABLED;
    rng_res = '0;
    rng_res.status = ST_RANGE;
    dir_rows = '{
      '{1'b0, 64'h4000_0000, 64'h0, 1'b0, 1, dis_res},
      '{1'b1, 64'h4000_0000, 64'h1000, 1'b0, 1, zero_res},
      '{1'b0, 64'h3FFF_FFFF, 64'h0, 1'b0, 1, rng_res},
      '{1'b0, 64'h8000_0000, 64'h0, 1'b1, 1, rng_res},
      '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 1, rng_res},
      '{1'b0, 64'h4000_0FFF, 64'h0, 1'b0, 0, zero_res},
      '{1'b0, 64'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 0, zero_res},
      '{1'b0, 64'h4000_0000, 64'h0, 1'b1, 0, zero_res},
      '{1'b0, 64'h4000_1000, 64'h0, 1'b0, 0, zero_res},
      '{1'b1, 64'h4000_0000, 64'h0, 1'b0, 1, zero_res},
      '{1'b1, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, 1'b0, 1, zero_res},
      '{1'b1, 64'h4000_0000, 64'h2000, 1'b0, 0, zero_res},
      '{1'b1, 64'h4000_0FFF, 64'h2, 1'b1, 0, zero_res},
      '{1'b1, 64'h3FFF_F000, 64'h2000, 1'b0, 0, zero_res},
      '{1'b1, 64'h7FFF_F000, 64'h1000, 1'b0, 0, zero_res},
      '{1'b1, 64'h4000_0000, 64'hFFFF_FFFF, 1'b0, 0, zero_res},
      '{1'b1, 64'h4000_2000, 64'h1, 1'b0, 0, zero_res},
      '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 1'b0, 1, zero_res}
    };
    mmu_on = 1'b0;
    base_reg = '0;
    for (int i = 0; i < SLOTS; i++) begin
      owner_ok[i] = 1'b0;
      owner_l2[i] = '0;
    end
    rst = 1'b1;
    start = 1'b0;
    action = 1'b0;
    address = '0;
    length = '0;
    user_exec = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 18; i++) begin
      if (i == 2) configure(1'b1, 48'hFFFF_FFFF_FFFF);
      issue(dir_rows[i].act, dir_rows[i].addr, dir_rows[i].len, dir_rows[i].ex,
            dir_rows[i].typed, dir_rows[i].res);
    end

    configure(1'b1, 48'($urandom) << 12 | 48'($urandom) << 24);
    for (int i = 0; i < 120; i++) begin
      quiet = (i >= 40 && i < 100);
      random_item();
    end
    quiet = 0;
    configure(1'b0, 48'd0);
    for (int i = 0; i < 30; i++) random_item();
    configure(1'b1, 48'd0);
    for (int i = 0; i < 80; i++) random_item();

    // Claim every pool slot, then mix maps of owned and random regions with checks.
    configure(1'b1, 48'hFFFF_FFFF_F000);
    for (int j = 0; j < SLOTS; j++)
      issue(ACT_MAP, DRAM_LO | (64'(j) << 21), 64'd0, 1'b0, 1'b0, '0);
    for (int i = 0; i < 12; i++) begin
      if (i % 4 == 0)
        issue(ACT_MAP, DRAM_LO | (64'(owner_l2[$urandom_range(SLOTS - 1)]) << 21)
              | (64'($urandom_range(511)) << 12), 64'd0, 1'($urandom_range(1)), 1'b0, '0);
      else if (i % 4 == 1)
        issue(ACT_MAP, DRAM_LO | (64'($urandom_range(511)) << 21), 64'd0, 1'b0, 1'b0, '0);
      else
        issue(1'b1, DRAM_LO + (64'(page_keys[$urandom_range(page_keys.size() - 1)]) << 12),
              64'($urandom_range(0, 8192)), 1'b0, 1'b0, '0);
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    page_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending, status %0d", $time, status);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.status !== status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, status);
          errors++;
        end
        if (exp_r.buffer_ok !== buffer_ok) begin
          $display("%0t: buffer_ok exp %0d got %0d", $time, exp_r.buffer_ok, buffer_ok);
          errors++;
        end
        if (exp_r.new_table !== new_table) begin
          $display("%0t: new_table exp %0d got %0d", $time, exp_r.new_table, new_table);
          errors++;
        end
        if (exp_r.table_slot !== table_slot) begin
          $display("%0t: table_slot exp %0d got %0d", $time, exp_r.table_slot, table_slot);
          errors++;
        end
        if (exp_r.l2_position !== l2_position) begin
          $display("%0t: l2_position exp %0d got %0d", $time, exp_r.l2_position,
                   l2_position);
          errors++;
        end
        if (exp_r.l2_descriptor !== l2_descriptor) begin
          $display("%0t: l2_descriptor exp %h got %h", $time, exp_r.l2_descriptor,
                   l2_descriptor);
          errors++;
        end
        if (exp_r.l3_position !== l3_position) begin
          $display("%0t: l3_position exp %0d got %0d", $time, exp_r.l3_position,
                   l3_position);
          errors++;
        end
        if (exp_r.l3_descriptor !== l3_descriptor) begin
          $display("%0t: l3_descriptor exp %h got %h", $time, exp_r.l3_descriptor,
                   l3_descriptor);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end
endmodule

// ===== sim.f =====
hw/rtl/upme_pkg.sv
hw/rtl/upme_ram.sv
hw/rtl/user_page_map_engine_top.sv
bench/tb_user_page_map_engine_top.sv
